### sv/csvcmd_pkg.sv
// Shared constants, types and keyword tables for the CSV command line decoder.
package csvcmd_pkg;

   localparam int KW_COUNT = 11;
   localparam int CMD_W    = 4;
   localparam int POS_W    = 3;
   localparam int FIELD_W  = 3;

   localparam int LINE_LIMIT_DEFAULT = 32;
   localparam logic [31:0] TEAM_ID_RESET = 32'h3230_3332;

   localparam logic [POS_W-1:0]   POS_MAX   = 3'd5;
   localparam logic [POS_W-1:0]   ID_LEN    = 3'd4;
   localparam logic [FIELD_W-1:0] FIELD_MAX = 3'd4;
   localparam logic [FIELD_W-1:0] FIELD_ID  = 3'd1;
   localparam logic [FIELD_W-1:0] FIELD_KW  = 3'd2;

   localparam logic [7:0] BYTE_CR    = 8'h0D;
   localparam logic [7:0] BYTE_COMMA = 8'h2C;
   localparam logic [7:0] BYTE_START = 8'h43;

   localparam logic [KW_COUNT-1:0] KW_ALL = '1;

   // command codes, one per keyword
   localparam logic [CMD_W-1:0] CMD_CX   = 4'd0;
   localparam logic [CMD_W-1:0] CMD_SIMP = 4'd1;
   localparam logic [CMD_W-1:0] CMD_SIM  = 4'd2;
   localparam logic [CMD_W-1:0] CMD_CAL  = 4'd3;
   localparam logic [CMD_W-1:0] CMD_ST   = 4'd4;
   localparam logic [CMD_W-1:0] CMD_CR   = 4'd5;
   localparam logic [CMD_W-1:0] CMD_BCN  = 4'd6;
   localparam logic [CMD_W-1:0] CMD_GB   = 4'd7;
   localparam logic [CMD_W-1:0] CMD_HS   = 4'd8;
   localparam logic [CMD_W-1:0] CMD_CAM  = 4'd9;
   localparam logic [CMD_W-1:0] CMD_IMU  = 4'd10;
   localparam logic [CMD_W-1:0] CMD_LAST = CMD_IMU;

   // control from the line tracker to the keyword filter
   typedef struct packed {
      logic             char_en;
      logic             close_en;
      logic [POS_W-1:0] pos;
   } kw_ctl_type;

   // keyword text, first character in the top byte, unused bytes zero
   function automatic logic [31:0] kw_text(input logic [CMD_W-1:0] code);
      logic [31:0] word;
      unique case (code)
         CMD_CX:   word = {"CX", 16'h0000};
         CMD_SIMP: word = "SIMP";
         CMD_SIM:  word = {"SIM", 8'h00};
         CMD_CAL:  word = {"CAL", 8'h00};
         CMD_ST:   word = {"ST", 16'h0000};
         CMD_CR:   word = {"CR", 16'h0000};
         CMD_BCN:  word = {"BCN", 8'h00};
         CMD_GB:   word = {"GB", 16'h0000};
         CMD_HS:   word = {"HS", 16'h0000};
         CMD_CAM:  word = {"CAM", 8'h00};
         CMD_IMU:  word = {"IMU", 8'h00};
         default:  word = 32'h0;
      endcase
      return word;
   endfunction

   function automatic logic [POS_W-1:0] kw_len(input logic [CMD_W-1:0] code);
      logic [POS_W-1:0] len;
      unique case (code)
         CMD_SIMP:                          len = 3'd4;
         CMD_SIM, CMD_CAL, CMD_BCN,
         CMD_CAM, CMD_IMU:                  len = 3'd3;
         CMD_CX, CMD_ST, CMD_CR,
         CMD_GB, CMD_HS:                    len = 3'd2;
         default:                           len = 3'd0;
      endcase
      return len;
   endfunction

endpackage

### sv/csv_command_line_decoder.sv
// Top level of the CSV command line decoder: line tracking, ID match and result register.
//
// Takes one received byte per word on the req channel and may accept a byte in every
// cycle. A line opens with 'C', fields are split by commas and a carriage return
// closes it; field one must equal the four ID characters in csr_team_id_chars (first
// character in bits 31..24) and field two must equal one keyword exactly, in which
// case one rsp word carries the keyword's code from the cycle after the carriage
// return is taken. Matching runs on the fly as bytes arrive, and the single result
// register sets the rate: req_stall rises only while a result waits and rsp_stall
// holds it. Lines with more than LINE_LIMIT bytes before the carriage return are
// dropped. The ID register may be written at any time through the csr channel,
// which is always ready.
module csv_command_line_decoder #(
   parameter int LINE_LIMIT = csvcmd_pkg::LINE_LIMIT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // byte input
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_rx_byte,
   // command output
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [csvcmd_pkg::CMD_W-1:0]  rsp_command_code,
   // ID register write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [31:0]                   csr_team_id_chars
);

   localparam int LEN_W = $clog2(LINE_LIMIT + 1);

   logic                                  in_line_ff, in_line_in;
   logic [csvcmd_pkg::FIELD_W-1:0]        field_ff, field_in;
   logic [csvcmd_pkg::POS_W-1:0]          pos_ff, pos_in;
   logic                                  id_ok_ff, id_ok_in;
   logic [csvcmd_pkg::KW_COUNT-1:0]       cand_ff, cand_in;
   logic [LEN_W-1:0]                      len_ff, len_in;
   logic [31:0]                           team_id_ff;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [csvcmd_pkg::CMD_W-1:0]          rsp_code_ff, rsp_code_in;

   logic                                  accept;
   logic                                  emit;
   logic [csvcmd_pkg::CMD_W-1:0]          emit_code;
   logic                                  is_cr;
   logic                                  is_comma;
   logic                                  too_long;
   logic                                  id_ok_close;
   logic [7:0]                            id_want;
   csvcmd_pkg::kw_ctl_type                kw_ctl;
   logic [csvcmd_pkg::KW_COUNT-1:0]       cand_upd;

   assign accept    = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign csr_ready = 1'b1;

   assign is_cr    = req_rx_byte == csvcmd_pkg::BYTE_CR;
   assign is_comma = req_rx_byte == csvcmd_pkg::BYTE_COMMA;
   assign too_long = len_ff >= LEN_W'(LINE_LIMIT);
   assign id_want  = team_id_ff[31 - 8*pos_ff[1:0] -: 8];

   // ID field fails at its end unless exactly four characters came
   assign id_ok_close = id_ok_ff &&
                        !(field_ff == csvcmd_pkg::FIELD_ID && pos_ff != csvcmd_pkg::ID_LEN);

   // keyword filter works on field two only
   always_comb begin
      kw_ctl.pos      = pos_ff;
      kw_ctl.close_en = in_line_ff && field_ff == csvcmd_pkg::FIELD_KW &&
                        (is_cr || (!too_long && is_comma));
      kw_ctl.char_en  = in_line_ff && field_ff == csvcmd_pkg::FIELD_KW &&
                        !is_cr && !too_long && !is_comma;
   end

   csvcmd_kw_filter u_kw_filter (
      .ctl      (kw_ctl),
      .rx_byte  (req_rx_byte),
      .cand_cur (cand_ff),
      .cand_nxt (cand_upd)
   );

   // pick the lowest surviving keyword
   always_comb begin
      emit_code = '0;
      for (int k = csvcmd_pkg::KW_COUNT - 1; k >= 0; k--) begin
         if (cand_upd[k]) begin
            emit_code = csvcmd_pkg::CMD_W'(k);
         end
      end
   end

   assign emit = accept && in_line_ff && is_cr && id_ok_close &&
                 field_ff >= csvcmd_pkg::FIELD_KW && (cand_upd != '0);

   // advance the line state for each accepted word
   always_comb begin
      in_line_in = in_line_ff;
      field_in   = field_ff;
      pos_in     = pos_ff;
      id_ok_in   = id_ok_ff;
      cand_in    = cand_ff;
      len_in     = len_ff;
      if (accept) begin
         if (!in_line_ff) begin
            if (req_rx_byte == csvcmd_pkg::BYTE_START) begin
               in_line_in = 1'b1;
               field_in   = '0;
               pos_in     = csvcmd_pkg::POS_W'(1);
               id_ok_in   = 1'b1;
               cand_in    = csvcmd_pkg::KW_ALL;
               len_in     = LEN_W'(1);
            end
         end else if (is_cr || too_long) begin
            // close or drop the line
            in_line_in = 1'b0;
            field_in   = '0;
            pos_in     = '0;
            id_ok_in   = 1'b1;
            cand_in    = csvcmd_pkg::KW_ALL;
            len_in     = '0;
         end else begin
            len_in  = len_ff + 1'b1;
            cand_in = cand_upd;
            if (is_comma) begin
               id_ok_in = id_ok_close;
               pos_in   = '0;
               if (field_ff < csvcmd_pkg::FIELD_MAX) begin
                  field_in = field_ff + 1'b1;
               end
            end else begin
               if (field_ff == csvcmd_pkg::FIELD_ID &&
                   (pos_ff >= csvcmd_pkg::ID_LEN || req_rx_byte != id_want)) begin
                  id_ok_in = 1'b0;
               end
               if (pos_ff < csvcmd_pkg::POS_MAX) begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         end
      end
   end

   // load a new result or drop the one taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_code_in  = rsp_code_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_code_in  = emit_code;
      end else if (!rsp_stall || accept) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_line_ff   <= 1'b0;
         field_ff     <= '0;
         pos_ff       <= '0;
         id_ok_ff     <= 1'b1;
         cand_ff      <= csvcmd_pkg::KW_ALL;
         len_ff       <= '0;
         team_id_ff   <= csvcmd_pkg::TEAM_ID_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_line_ff   <= in_line_in;
         field_ff     <= field_in;
         pos_ff       <= pos_in;
         id_ok_ff     <= id_ok_in;
         cand_ff      <= cand_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            team_id_ff <= csr_team_id_chars;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_code_ff <= rsp_code_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_command_code = rsp_code_ff;

   // a fresh result only follows an accepted carriage return
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !$past(rsp_valid_ff && rsp_stall) |->
         $past(accept && req_rx_byte == csvcmd_pkg::BYTE_CR))
      else $error("result without a closing carriage return");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_code_ff <= csvcmd_pkg::CMD_LAST)
      else $error("command code out of range");

   assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(LINE_LIMIT))
      else $error("line length beyond limit");

   assert property (@(posedge clock) disable iff (reset)
      !in_line_ff |-> len_ff == '0 && field_ff == '0 && cand_ff == csvcmd_pkg::KW_ALL)
      else $error("line state not cleared while idle");

endmodule

### sv/csvcmd_kw_filter.sv
// Keyword candidate filter: narrows the set of keywords still matching field two.
module csvcmd_kw_filter (
   input  csvcmd_pkg::kw_ctl_type               ctl,
   input  logic [7:0]                           rx_byte,
   input  logic [csvcmd_pkg::KW_COUNT-1:0]      cand_cur,
   output logic [csvcmd_pkg::KW_COUNT-1:0]      cand_nxt
);

   logic [31:0] text;
   logic [7:0]  want;
   logic [csvcmd_pkg::POS_W-1:0] len;

   // drop every keyword that the current character or the field end rules out
   always_comb begin
      cand_nxt = cand_cur;
      text     = '0;
      want     = '0;
      len      = '0;
      for (int k = 0; k < csvcmd_pkg::KW_COUNT; k++) begin
         text = csvcmd_pkg::kw_text(csvcmd_pkg::CMD_W'(k));
         len  = csvcmd_pkg::kw_len(csvcmd_pkg::CMD_W'(k));
         want = text[31 - 8*ctl.pos[1:0] -: 8];
         if (ctl.close_en && ctl.pos != len) begin
            cand_nxt[k] = 1'b0;
         end
         if (ctl.char_en && (ctl.pos >= len || rx_byte != want)) begin
            cand_nxt[k] = 1'b0;
         end
      end
   end

endmodule

### sim/csv_command_checker.sv
// Checker for the CSV command line decoder: tracks lines, predicts command codes, compares.
`timescale 1ns / 1ps

module csv_command_checker #(
   parameter int LINE_LIMIT = csvcmd_pkg::LINE_LIMIT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [7:0]                    req_rx_byte,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [csvcmd_pkg::CMD_W-1:0]  rsp_command_code,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [31:0]                   csr_team_id_chars,
   output int                            failures,
   output int                            pending_codes,
   output int                            codes_checked
);

   // predicted decoder state
   logic [31:0]                      team_id;
   bit                               line_open;
   logic [csvcmd_pkg::FIELD_W-1:0]   field_idx;
   logic [csvcmd_pkg::POS_W-1:0]     char_pos;
   bit                               id_ok;
   logic [csvcmd_pkg::KW_COUNT-1:0]  kw_alive;
   int                               line_len;

   logic [csvcmd_pkg::CMD_W-1:0]     expected_codes[$];

   // keyword spelling, first character in the top byte, unused bytes zero
   function automatic logic [31:0] keyword_bytes(input int code);
      case (code)
         csvcmd_pkg::CMD_CX:   return {"CX", 16'h0000};
         csvcmd_pkg::CMD_SIMP: return "SIMP";
         csvcmd_pkg::CMD_SIM:  return {"SIM", 8'h00};
         csvcmd_pkg::CMD_CAL:  return {"CAL", 8'h00};
         csvcmd_pkg::CMD_ST:   return {"ST", 16'h0000};
         csvcmd_pkg::CMD_CR:   return {"CR", 16'h0000};
         csvcmd_pkg::CMD_BCN:  return {"BCN", 8'h00};
         csvcmd_pkg::CMD_GB:   return {"GB", 16'h0000};
         csvcmd_pkg::CMD_HS:   return {"HS", 16'h0000};
         csvcmd_pkg::CMD_CAM:  return {"CAM", 8'h00};
         csvcmd_pkg::CMD_IMU:  return {"IMU", 8'h00};
         default:              return 32'h0;
      endcase
   endfunction

   // count leading non-zero characters of a keyword
   function automatic int keyword_length(input int code);
      logic [31:0] w;
      int          n;
      w = keyword_bytes(code);
      n = 0;
      while (n < 4 && w[31-8*n -: 8] != 8'h00)
         n++;
      return n;
   endfunction

   task automatic clear_line();
      line_open = 1'b0;
      field_idx = '0;
      char_pos  = '0;
      id_ok     = 1'b1;
      kw_alive  = csvcmd_pkg::KW_ALL;
      line_len  = 0;
   endtask

   // a field ends: its length must fit the ID or the keyword
   task automatic close_field();
      if (field_idx == csvcmd_pkg::FIELD_ID && char_pos != csvcmd_pkg::ID_LEN)
         id_ok = 1'b0;
      if (field_idx == csvcmd_pkg::FIELD_KW) begin
         for (int k = 0; k < csvcmd_pkg::KW_COUNT; k++)
            if (int'(char_pos) != keyword_length(k))
               kw_alive[k] = 1'b0;
      end
   endtask

   // one ordinary character of the current field
   task automatic field_char(input logic [7:0] b);
      int          p;
      logic [31:0] w;
      p = int'(char_pos);
      if (field_idx == csvcmd_pkg::FIELD_ID) begin
         if (p >= 4)
            id_ok = 1'b0;
         else if (b != team_id[8*(3-p) +: 8])
            id_ok = 1'b0;
      end else if (field_idx == csvcmd_pkg::FIELD_KW) begin
         for (int k = 0; k < csvcmd_pkg::KW_COUNT; k++) begin
            w = keyword_bytes(k);
            if (p >= keyword_length(k))
               kw_alive[k] = 1'b0;
            else if (b != w[8*(3-p) +: 8])
               kw_alive[k] = 1'b0;
         end
      end
      if (char_pos < csvcmd_pkg::POS_MAX)
         char_pos++;
   endtask

   // advance the line state by one byte, queue a code when a line closes well
   task automatic decode_byte(input logic [7:0] b);
      bit found;
      found = 1'b0;
      if (!line_open) begin
         if (b == csvcmd_pkg::BYTE_START) begin
            clear_line();
            line_open = 1'b1;
            char_pos  = csvcmd_pkg::POS_W'(1);
            line_len  = 1;
         end
      end else if (b == csvcmd_pkg::BYTE_CR) begin
         close_field();
         if (field_idx >= csvcmd_pkg::FIELD_KW && id_ok) begin
            for (int k = 0; k < csvcmd_pkg::KW_COUNT; k++)
               if (!found && kw_alive[k]) begin
                  expected_codes.push_back(csvcmd_pkg::CMD_W'(k));
                  found = 1'b1;
               end
         end
         clear_line();
      end else if (line_len >= LINE_LIMIT) begin
         // drop the overlong line and the byte with it
         clear_line();
      end else begin
         line_len++;
         if (b == csvcmd_pkg::BYTE_COMMA) begin
            close_field();
            if (field_idx < csvcmd_pkg::FIELD_MAX)
               field_idx++;
            char_pos = '0;
         end else begin
            field_char(b);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         team_id       = csvcmd_pkg::TEAM_ID_RESET;
         failures      = 0;
         codes_checked = 0;
         clear_line();
         expected_codes.delete();
      end else begin
         if (csr_valid && csr_ready)
            team_id = csr_team_id_chars;
         if (req_valid && !req_stall)
            decode_byte(req_rx_byte);
         // compare each result word with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_codes.size() == 0) begin
               $error("command_code: expected none, actual %0d", rsp_command_code);
               failures++;
            end else begin
               if (rsp_command_code !== expected_codes[0]) begin
                  $error("command_code: expected %0d, actual %0d",
                         expected_codes[0], rsp_command_code);
                  failures++;
               end
               void'(expected_codes.pop_front());
               codes_checked++;
            end
         end
      end
      pending_codes = expected_codes.size();
   end

endmodule

### sim/tb_csv_command_line_decoder.sv
// Testbench top for the CSV command line decoder: byte stimulus, ID writes and verdict.
`timescale 1ns / 1ps

module tb_csv_command_line_decoder;

   localparam int LINE_LIMIT = csvcmd_pkg::LINE_LIMIT_DEFAULT;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [7:0]                   req_rx_byte = 8'h00;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [csvcmd_pkg::CMD_W-1:0] rsp_command_code;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [31:0]                  csr_team_id_chars = 32'h0;

   int failures;
   int pending_codes;
   int codes_checked;

   logic [7:0]  line_q[$];
   logic [31:0] id_now;
   logic [31:0] id_settings[5];
   int          line_bytes;
   int          noise_bytes;
   bit          no_gaps;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   csv_command_line_decoder #(
      .LINE_LIMIT (LINE_LIMIT)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_command_code  (rsp_command_code),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_team_id_chars (csr_team_id_chars)
   );

   csv_command_checker #(
      .LINE_LIMIT (LINE_LIMIT)
   ) i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_command_code  (rsp_command_code),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_team_id_chars (csr_team_id_chars),
      .failures          (failures),
      .pending_codes     (pending_codes),
      .codes_checked     (codes_checked)
   );

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      if (no_gaps)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // any byte that neither splits a field nor ends the line
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do
         b = 8'($urandom_range(0, 255));
      while (b == csvcmd_pkg::BYTE_COMMA || b == csvcmd_pkg::BYTE_CR);
      return b;
   endfunction

   function automatic logic [31:0] printable_id();
      logic [31:0] w;
      for (int i = 0; i < 4; i++) begin
         do
            w[8*i +: 8] = 8'($urandom_range(8'h21, 8'h7E));
         while (w[8*i +: 8] == csvcmd_pkg::BYTE_COMMA);
      end
      return w;
   endfunction

   // present one byte word and hold it until taken; returns at a falling edge
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         line_q.push_back(s[i]);
   endtask

   task automatic push_word(input logic [31:0] w, input int n);
      for (int i = 0; i < n; i++)
         line_q.push_back(w[31-8*i -: 8]);
   endtask

   task automatic send_line();
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < line_q.size(); i++)
         send_byte(line_q[i]);
      line_bytes += line_q.size();
      line_q.delete();
   endtask

   task automatic text_line(input string s);
      push_text(s);
      line_q.push_back(csvcmd_pkg::BYTE_CR);
      send_line();
   endtask

   // bytes between lines; no 'C', so no line opens by accident
   task automatic send_noise(input int n);
      logic [7:0] b;
      no_gaps = 1'b0;
      repeat (n) begin
         do
            b = 8'($urandom_range(0, 255));
         while (b == csvcmd_pkg::BYTE_START);
         send_byte(b);
         noise_bytes++;
      end
   endtask

   // build one random line, mostly well formed
   task automatic build_line();
      int                           kind;
      int                           len;
      int                           n;
      logic [csvcmd_pkg::CMD_W-1:0] code;
      logic [31:0]                  kw;
      logic [31:0]                  w;
      kind = $urandom_range(0, 99);
      code = csvcmd_pkg::CMD_W'($urandom_range(0, csvcmd_pkg::KW_COUNT - 1));
      kw   = csvcmd_pkg::kw_text(code);
      len  = int'(csvcmd_pkg::kw_len(code));
      line_q.push_back(csvcmd_pkg::BYTE_START);
      if (kind < 72) begin
         repeat ($urandom_range(0, 3)) line_q.push_back(plain_byte());
         line_q.push_back(csvcmd_pkg::BYTE_COMMA);
         // ID field: usually right, sometimes short, long or with one byte wrong
         if ($urandom_range(0, 9) < 8) begin
            push_word(id_now, 4);
         end else begin
            case ($urandom_range(0, 2))
               0: push_word(id_now, $urandom_range(0, 3));
               1: begin
                  push_word(id_now, 4);
                  line_q.push_back(plain_byte());
               end
               default: begin
                  w = id_now;
                  w[8*$urandom_range(0, 3) +: 8] ^= 8'($urandom_range(1, 255));
                  push_word(w, 4);
               end
            endcase
         end
         line_q.push_back(csvcmd_pkg::BYTE_COMMA);
         // keyword field: usually exact, sometimes a prefix, an extension, altered or random bytes
         if ($urandom_range(0, 9) < 8) begin
            push_word(kw, len);
         end else begin
            case ($urandom_range(0, 3))
               0: push_word(kw, $urandom_range(0, len - 1));
               1: begin
                  push_word(kw, len);
                  line_q.push_back(plain_byte());
               end
               2: begin
                  w = kw;
                  w[31-8*$urandom_range(0, len - 1) -: 8] ^= 8'($urandom_range(1, 255));
                  push_word(w, len);
               end
               default: repeat ($urandom_range(0, 5)) line_q.push_back(plain_byte());
            endcase
         end
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) begin
               line_q.push_back(csvcmd_pkg::BYTE_COMMA);
               repeat ($urandom_range(0, 3)) line_q.push_back(plain_byte());
            end
         end
      end else if (kind < 82) begin
         // valid fields after filler, total length around the limit
         n = LINE_LIMIT - 7 - len + $urandom_range(0, 4) - 2;
         repeat (n) line_q.push_back(plain_byte());
         line_q.push_back(csvcmd_pkg::BYTE_COMMA);
         push_word(id_now, 4);
         line_q.push_back(csvcmd_pkg::BYTE_COMMA);
         push_word(kw, len);
      end else if (kind < 92) begin
         // line ends before the keyword field
         repeat ($urandom_range(0, 3)) line_q.push_back(plain_byte());
         if ($urandom_range(0, 1) == 1) begin
            line_q.push_back(csvcmd_pkg::BYTE_COMMA);
            push_word(id_now, $urandom_range(0, 4));
         end
      end else begin
         repeat ($urandom_range(1, 15)) line_q.push_back(8'($urandom_range(0, 255)));
      end
      line_q.push_back(csvcmd_pkg::BYTE_CR);
   endtask

   // drop valid, drain the results, then let the block settle
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_codes != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_team_id(input logic [31:0] value);
      csr_valid         <= 1'b1;
      csr_team_id_chars <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      id_now = value;
   endtask

   // result side: stall in runs, short mostly, with long free stretches
   initial begin
      int  r;
      int  n;
      bit  v;
      forever begin
         r = $urandom_range(0, 99);
         if (r < 50) begin
            v = 1'b0;
            n = $urandom_range(1, 8);
         end else if (r < 58) begin
            v = 1'b0;
            n = $urandom_range(40, 150);
         end else if (r < 92) begin
            v = 1'b1;
            n = $urandom_range(1, 3);
         end else begin
            v = 1'b1;
            n = $urandom_range(10, 50);
         end
         repeat (n) begin
            @(negedge clock);
            rsp_stall <= v;
         end
      end
   end

   // hard stop should the run hang
   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int target;
      line_bytes  = 0;
      noise_bytes = 0;
      no_gaps     = 1'b0;
      id_now      = csvcmd_pkg::TEAM_ID_RESET;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed lines under the reset ID
      text_line("C,2032,CX");
      text_line("CZ,2032,SIMP");
      text_line("C,2032,SIM");
      text_line("C,2032,SIMPX");
      text_line("C,2032,CAM,a,b,c,d");
      line_q.push_back(csvcmd_pkg::BYTE_CR);
      push_text("xyz");
      send_line();
      text_line("CCC,2032,CR");
      text_line("C,2032,C");
      text_line("C,2032");
      text_line("C");
      text_line("C,2033,ST");
      text_line("C,20322,ST");
      text_line("C,203,ST");
      text_line("C,2032,ST");
      // exactly at the length limit, then one byte over
      for (int extra = 0; extra < 2; extra++) begin
         push_text("C");
         repeat (LINE_LIMIT - 9 + extra) push_text("a");
         push_text(",2032,GB");
         line_q.push_back(csvcmd_pkg::BYTE_CR);
         send_line();
      end
      // the byte past the limit is a 'C': dropped, the rest ignored
      push_text("C");
      repeat (LINE_LIMIT - 1) push_text("a");
      text_line("C,2032,HS");
      push_text("C");
      line_q.push_back(8'h00);
      text_line(",2032,IMU");
      push_text("C,2032,BCN");
      line_q.push_back(8'h00);
      line_q.push_back(csvcmd_pkg::BYTE_CR);
      send_line();
      text_line("C,2032,CAL");
      text_line("C,2032,HS");
      text_line("C,2032,BCN");

      // random phases, each under its own ID setting
      id_settings[0] = 32'h0000_0000;
      id_settings[1] = 32'hFFFF_FFFF;
      id_settings[2] = printable_id();
      id_settings[3] = $urandom();
      id_settings[4] = csvcmd_pkg::TEAM_ID_RESET;
      foreach (id_settings[ph]) begin
         settle();
         write_team_id(id_settings[ph]);
         target = line_bytes + 135;
         while (line_bytes < target) begin
            if ($urandom_range(0, 4) == 0)
               send_noise($urandom_range(1, 4));
            build_line();
            send_line();
         end
      end

      settle();
      repeat (16) @(negedge clock);
      $display("Sent %0d line bytes and %0d idle bytes under five ID settings,",
               line_bytes, noise_bytes);
      $display("with %0d command codes received and compared.", codes_checked);
      if (failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

### files.f
sv/csvcmd_pkg.sv
sv/csvcmd_kw_filter.sv
sv/csv_command_line_decoder.sv
sim/csv_command_checker.sv
sim/tb_csv_command_line_decoder.sv
